### rtl/core/crc8frm_pkg.sv
package crc8frm_pkg;

  localparam logic [7:0] CRC_POLY   = 8'h31;
  localparam logic [7:0] CRC_INIT   = 8'hFF;
  localparam logic [2:0] ALIGN_MASK = 3'h7;
  localparam logic [7:0] TOP_BIT    = 8'h80;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_VERIFY = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ADDR_ERR = 2'd1;
  localparam logic [1:0] ST_CRC_ERR  = 2'd2;
  localparam logic [1:0] ST_NO_OPEN  = 2'd3;

  localparam logic REG_FIRST = 1'b0;
  localparam logic REG_LAST  = 1'b1;

  localparam int PADDR_W = 3;

  typedef struct packed {
    logic [31:0] first_addr;
    logic [31:0] last_addr;
  } region_t;

  typedef struct packed {
    logic        op;
    logic        opens_transfer;
    logic [31:0] start_addr;
    logic [15:0] total_len;
    logic [31:0] data_word;
    logic [63:0] stored_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] flash_addr;
    logic [63:0] program_word;
    logic [31:0] read_data;
    logic [2:0]  valid_bytes;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if ((c & TOP_BIT) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] crc8_calc(logic [31:0] data, logic [2:0] count);
    logic [7:0] crc;
    crc = CRC_INIT;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < count) begin
        crc = crc8_byte(crc, data[8*i +: 8]);
      end
    end
    return crc;
  endfunction

  function automatic logic [31:0] byte_mask(logic [2:0] count);
    logic [31:0] m;
    case (count)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

### rtl/core/crc8frm_if.sv
interface crc8frm_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic        opens_transfer;
  logic [31:0] start_addr;
  logic [15:0] total_len;
  logic [31:0] data_word;
  logic [63:0] stored_word;

  modport source (output valid, output op, output opens_transfer, output start_addr,
                  output total_len, output data_word, output stored_word, input ready);
  modport sink (input valid, input op, input opens_transfer, input start_addr,
                input total_len, input data_word, input stored_word, output ready);
endinterface

interface crc8frm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] flash_addr;
  logic [63:0] program_word;
  logic [31:0] read_data;
  logic [2:0]  valid_bytes;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output flash_addr, output program_word, output read_data,
                  output valid_bytes, output status, output last, input ready);
  modport sink (input valid, input flash_addr, input program_word, input read_data,
                input valid_bytes, input status, input last, output ready);
endinterface

### rtl/core/crc8frm_regs.sv
module crc8frm_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [crc8frm_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output crc8frm_pkg::region_t             region
);
  import crc8frm_pkg::*;

  region_t region_r;
  logic    wr_en;
  logic    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[2];
  assign region = region_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r.first_addr <= 32'h0000_0000;
      region_r.last_addr  <= 32'hFFFF_FFFF;
    end else if (wr_en) begin
      unique case (idx)
        REG_FIRST: region_r.first_addr <= pwdata;
        REG_LAST:  region_r.last_addr  <= pwdata;
        default:   region_r.first_addr <= region_r.first_addr;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FIRST: prdata = region_r.first_addr;
      REG_LAST:  prdata = region_r.last_addr;
      default:   prdata = 32'h0000_0000;
    endcase
  end

endmodule

### rtl/core/crc8frm_engine.sv
module crc8frm_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  crc8frm_in_if.sink           in_ch,
  crc8frm_out_if.source        out_ch,
  input  crc8frm_pkg::region_t region
);
  import crc8frm_pkg::*;

  logic        s1_v_r;
  in_item_t    s1_r;
  logic        out_v_r;
  out_item_t   res_r;
  out_item_t   res_nxt;

  logic [31:0] nba_r,  nba_nxt;
  logic [15:0] left_r, left_nxt;
  logic        open_r, open_nxt;

  logic        advance;
  logic        fire;

  logic [14:0] blocks;
  logic [32:0] foot_last;
  logic        addr_err;
  logic [15:0] cur_left;
  logic [31:0] cur_addr;
  logic        active;
  logic [2:0]  count;
  logic [31:0] mask;
  logic [31:0] data;
  logic [7:0]  crc;

  assign advance      = !out_v_r || out_ch.ready;
  assign in_ch.ready  = !s1_v_r || advance;
  assign fire         = advance && s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_r.op             <= in_ch.op;
      s1_r.opens_transfer <= in_ch.opens_transfer;
      s1_r.start_addr     <= in_ch.start_addr;
      s1_r.total_len      <= in_ch.total_len;
      s1_r.data_word      <= in_ch.data_word;
      s1_r.stored_word    <= in_ch.stored_word;
    end
  end

  // footprint is ceil(len/4) doublewords, checked without wrap
  always_comb begin
    blocks    = 15'(({1'b0, s1_r.total_len} + 17'd3) >> 2);
    foot_last = {1'b0, s1_r.start_addr} + {15'b0, blocks, 3'b000} - 33'd1;
    addr_err  = ((s1_r.start_addr[2:0] & ALIGN_MASK) != 3'd0) ||
                (s1_r.total_len == 16'd0) ||
                (s1_r.start_addr < region.first_addr) ||
                (foot_last > {1'b0, region.last_addr});
  end

  always_comb begin
    cur_left = s1_r.opens_transfer ? s1_r.total_len  : left_r;
    cur_addr = s1_r.opens_transfer ? s1_r.start_addr : nba_r;
    active   = s1_r.opens_transfer ? !addr_err       : open_r;
    count    = (cur_left >= 16'd4) ? 3'd4 : cur_left[2:0];
    mask     = byte_mask(count);
    data     = ((s1_r.op == OP_VERIFY) ? s1_r.stored_word[31:0] : s1_r.data_word) & mask;
    crc      = crc8_calc(data, count);
  end

  always_comb begin
    res_nxt  = '0;
    nba_nxt  = nba_r;
    left_nxt = left_r;
    open_nxt = 1'b0;
    if (!active) begin
      res_nxt.status = s1_r.opens_transfer ? ST_ADDR_ERR : ST_NO_OPEN;
      res_nxt.last   = 1'b1;
    end else begin
      res_nxt.flash_addr  = cur_addr;
      res_nxt.valid_bytes = count;
      if (s1_r.op == OP_VERIFY && crc != s1_r.stored_word[39:32]) begin
        res_nxt.status = ST_CRC_ERR;
        res_nxt.last   = 1'b1;
      end else begin
        if (s1_r.op == OP_VERIFY) begin
          res_nxt.read_data = data;
        end else begin
          res_nxt.program_word = {24'h00_0000, crc, data};
        end
        left_nxt      = cur_left - {13'b0, count};
        nba_nxt       = cur_addr + 32'd8;
        open_nxt      = (left_nxt != 16'd0);
        res_nxt.last  = (left_nxt == 16'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nba_r  <= 32'h0000_0000;
      left_r <= 16'h0000;
      open_r <= 1'b0;
    end else if (fire) begin
      nba_r  <= nba_nxt;
      left_r <= left_nxt;
      open_r <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.flash_addr   = res_r.flash_addr;
  assign out_ch.program_word = res_r.program_word;
  assign out_ch.read_data    = res_r.read_data;
  assign out_ch.valid_bytes  = res_r.valid_bytes;
  assign out_ch.status       = res_r.status;
  assign out_ch.last         = res_r.last;

endmodule

### rtl/core/crc8_flash_record_codec.sv
// Pipeline: an accepted block is held in the input register, then in the result register.
// Throughput: one block per cycle; the input register and the result register
// both keep moving while the result side accepts every cycle.
// Reset: synchronous, active low; clears the pipeline valids and the transfer
// state, and loads the region registers with the full address range.
module crc8_flash_record_codec (
  input  logic                             clk,
  input  logic                             rst_n,
  crc8frm_in_if.sink                       in_ch,
  crc8frm_out_if.source                    out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [crc8frm_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import crc8frm_pkg::*;

  region_t region;

  crc8frm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .region  (region)
  );

  crc8frm_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .region (region)
  );

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |-> out_ch.last)
    else $error("error result without last");

  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |->
      out_ch.program_word == 64'd0 && out_ch.read_data == 32'd0)
    else $error("error result carries data");

  a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == ST_ADDR_ERR || out_ch.status == ST_NO_OPEN) |->
      out_ch.flash_addr == 32'd0 && out_ch.valid_bytes == 3'd0)
    else $error("rejected block has address or count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_OK |->
      out_ch.valid_bytes != 3'd0 && out_ch.valid_bytes <= 3'd4)
    else $error("valid_bytes out of range");

endmodule
